// File: rtl/core/calendar_time_to_epoch_unit_defines.svh
// Assertion macros shared by the conversion unit.
`ifndef CALENDAR_TIME_TO_EPOCH_UNIT_DEFINES_SVH
`define CALENDAR_TIME_TO_EPOCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CTTE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define CTTE_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define CTTE_ASSERT(lbl, prop, msg)
`define CTTE_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/core/ctte_pkg.sv
package ctte_pkg;

   localparam logic [15:0] YEAR_MIN = 16'd1900;
   localparam logic [15:0] YEAR_MAX = 16'd9999;
   localparam logic [15:0] SUBSECOND_MAX = 16'd1000;
   localparam logic signed [15:0] ZONE_UNSPECIFIED = 16'sd2047;
   localparam logic signed [15:0] ZONE_LIMIT = 16'sd1440;
   localparam logic [7:0] HOUR_MAX = 8'd23;
   localparam logic [7:0] MINUTE_MAX = 8'd59;
   localparam logic [7:0] SECOND_MAX = 8'd59;
   localparam logic [7:0] MONTH_MAX = 8'd12;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [40:0] SECONDS_PER_DAY = 41'd86400;
   // Days from the start of year 1 to the start of 1970.
   localparam logic [23:0] EPOCH_DAY_OFFSET = 24'd719162;
   // floor(y / 100) == (y * 5243) >> 19 for every y below 43699.
   localparam logic [28:0] CENTURY_RECIP = 29'd5243;
   localparam int CENTURY_SHIFT = 19;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } ctte_ctrl_type;

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd2:                       len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:         len = 5'd31;
         default:                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/ctte_req_if.sv
interface ctte_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        year_value;
   logic [7:0]         month_value;
   logic [7:0]         day_value;
   logic [7:0]         hour_value;
   logic [7:0]         minute_value;
   logic [7:0]         second_value;
   logic [15:0]        subsecond_word;
   logic signed [15:0] zone_minutes;
   logic [7:0]         flag_bits;
   logic [23:0]        reserved_bytes;

   modport source (
      output valid, year_value, month_value, day_value, hour_value, minute_value,
             second_value, subsecond_word, zone_minutes, flag_bits, reserved_bytes,
      input  ready
   );
   modport sink (
      input  valid, year_value, month_value, day_value, hour_value, minute_value,
             second_value, subsecond_word, zone_minutes, flag_bits, reserved_bytes,
      output ready
   );
endinterface

// File: rtl/core/ctte_rsp_if.sv
interface ctte_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_valid;
   logic [31:0] epoch_seconds;

   modport source (output valid, is_valid, epoch_seconds, input ready);
   modport sink (input valid, is_valid, epoch_seconds, output ready);
endinterface

// File: rtl/core/ctte_check.sv
module ctte_check (
   input  logic [15:0]        year_value,
   input  logic [7:0]         month_value,
   input  logic [7:0]         day_value,
   input  logic [7:0]         hour_value,
   input  logic [7:0]         minute_value,
   input  logic [7:0]         second_value,
   input  logic [15:0]        subsecond_word,
   input  logic signed [15:0] zone_minutes,
   input  logic [7:0]         flag_bits,
   input  logic [23:0]        reserved_bytes,
   output logic               fields_ok
);

   logic year_ok;
   logic month_ok;
   logic clock_ok;
   logic zone_ok;
   logic misc_ok;

   // The upper day limit depends on the leap year and is checked later.
   always_comb begin
      year_ok  = (year_value >= ctte_pkg::YEAR_MIN) && (year_value <= ctte_pkg::YEAR_MAX);
      month_ok = (month_value != 8'd0) && (month_value <= ctte_pkg::MONTH_MAX)
                 && (day_value != 8'd0);
      clock_ok = (hour_value <= ctte_pkg::HOUR_MAX) && (minute_value <= ctte_pkg::MINUTE_MAX)
                 && (second_value <= ctte_pkg::SECOND_MAX);
      zone_ok  = (zone_minutes == ctte_pkg::ZONE_UNSPECIFIED)
                 || ((zone_minutes >= -ctte_pkg::ZONE_LIMIT)
                     && (zone_minutes <= ctte_pkg::ZONE_LIMIT));
      misc_ok  = (subsecond_word <= ctte_pkg::SUBSECOND_MAX) && (flag_bits[7:2] == 6'd0)
                 && (reserved_bytes == 24'd0);
      fields_ok = year_ok && month_ok && clock_ok && zone_ok && misc_ok;
   end

endmodule

// File: rtl/core/ctte_calc.sv
module ctte_calc (
   input  logic                    clock,
   input  ctte_pkg::ctte_ctrl_type ctrl,
   input  logic                    fields_ok,
   input  logic [15:0]             year_value,
   input  logic [7:0]              month_value,
   input  logic [7:0]              day_value,
   input  logic [7:0]              hour_value,
   input  logic [7:0]              minute_value,
   input  logic [7:0]              second_value,
   input  logic signed [15:0]      zone_minutes,
   output logic                    is_valid,
   output logic [31:0]             epoch_seconds
);

   logic [28:0]        century_prod;
   logic signed [11:0] zone_short;
   logic signed [19:0] zone_sec;
   logic signed [19:0] tod_in;

   logic               s1_ok_ff;
   logic [13:0]        s1_year_ff;
   logic [6:0]         s1_century_ff;
   logic [3:0]         s1_month_ff;
   logic [7:0]         s1_day_ff;
   logic signed [19:0] s1_tod_ff;

   logic [13:0]        year_rem;
   logic               leap;
   logic [7:0]         month_len;
   logic               day_ok;
   logic [6:0]         prev_century;
   logic [13:0]        prev_year;
   logic [23:0]        days_in;

   logic               s2_ok_ff;
   logic signed [23:0] s2_days_ff;
   logic signed [19:0] s2_tod_ff;

   logic signed [40:0] secs_wide;
   logic               fits;

   logic               is_valid_ff;
   logic [31:0]        epoch_ff;

   // Stage 1: century quotient of the year and the time of day in seconds, less the zone offset.
   always_comb begin
      century_prod = {13'd0, year_value} * ctte_pkg::CENTURY_RECIP;
      zone_short   = zone_minutes[11:0];
      zone_sec     = (zone_minutes == ctte_pkg::ZONE_UNSPECIFIED) ? 20'sd0
                     : 20'(zone_short) * 20'sd60;
      tod_in       = $signed(20'(hour_value[4:0]) * 20'd3600
                             + 20'(minute_value[5:0]) * 20'd60
                             + 20'(second_value[5:0])) - zone_sec;
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_en) begin
         s1_ok_ff      <= fields_ok;
         s1_year_ff    <= year_value[13:0];
         s1_century_ff <= century_prod[ctte_pkg::CENTURY_SHIFT +: 7];
         s1_month_ff   <= month_value[3:0];
         s1_day_ff     <= day_value;
         s1_tod_ff     <= tod_in;
      end
   end

   // Stage 2: leap year, day range check and the day count since 1970.
   always_comb begin
      year_rem     = s1_year_ff - 14'(s1_century_ff) * 14'd100;
      leap         = (s1_year_ff[1:0] == 2'd0)
                     && ((year_rem != 14'd0) || (s1_century_ff[1:0] == 2'd0));
      month_len    = 8'(ctte_pkg::month_length(s1_month_ff))
                     + 8'((s1_month_ff == ctte_pkg::MONTH_FEB) && leap);
      day_ok       = s1_day_ff <= month_len;
      prev_century = s1_century_ff - 7'(year_rem == 14'd0);
      prev_year    = s1_year_ff - 14'd1;
      days_in      = 24'(prev_year) * 24'd365 + 24'(prev_year >> 2)
                     - 24'(prev_century) + 24'(prev_century >> 2)
                     - ctte_pkg::EPOCH_DAY_OFFSET
                     + 24'(ctte_pkg::days_before_month(s1_month_ff))
                     + 24'((s1_month_ff > ctte_pkg::MONTH_FEB) && leap)
                     + 24'(s1_day_ff) - 24'd1;
   end

   always_ff @(posedge clock) begin
      if (ctrl.s2_en) begin
         s2_ok_ff   <= s1_ok_ff && day_ok;
         s2_days_ff <= $signed(days_in);
         s2_tod_ff  <= s1_tod_ff;
      end
   end

   // Stage 3: seconds and the 32-bit range check.
   always_comb begin
      secs_wide = 41'(s2_days_ff) * $signed(ctte_pkg::SECONDS_PER_DAY) + 41'(s2_tod_ff);
      fits      = secs_wide[40:32] == 9'd0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.s3_en) begin
         is_valid_ff <= s2_ok_ff && fits;
         epoch_ff    <= (s2_ok_ff && fits) ? secs_wide[31:0] : 32'd0;
      end
   end

   assign is_valid      = is_valid_ff;
   assign epoch_seconds = epoch_ff;

endmodule

// File: rtl/core/calendar_time_to_epoch_unit.sv
// Channel  Direction  Word
// req      in         one broken-down time record
// rsp      out        valid flag and seconds since 1970 UTC
//
// One record is taken per cycle while the result channel does not stall the pipeline.
// The latency is set by the input register and three stages: century quotient,
// day count, and the seconds multiply with its range check.
// Reset is synchronous and active high; it empties every stage.
// A stalled result holds only the stages behind it that are full.
`include "calendar_time_to_epoch_unit_defines.svh"

module calendar_time_to_epoch_unit (
   input logic          clock,
   input logic          reset,
   ctte_req_if.sink     req_port,
   ctte_rsp_if.source   rsp_port
);

   logic               s0_valid_ff;
   logic               s1_valid_ff;
   logic               s2_valid_ff;
   logic               s3_valid_ff;
   logic               s0_en;
   ctte_pkg::ctte_ctrl_type ctrl;

   logic [15:0]        year_ff;
   logic [7:0]         month_ff;
   logic [7:0]         day_ff;
   logic [7:0]         hour_ff;
   logic [7:0]         minute_ff;
   logic [7:0]         second_ff;
   logic [15:0]        subsecond_ff;
   logic signed [15:0] zone_ff;
   logic [7:0]         flag_ff;
   logic [23:0]        reserved_ff;
   logic               fields_ok;

   always_comb begin
      ctrl.s3_en = !s3_valid_ff || rsp_port.ready;
      ctrl.s2_en = !s2_valid_ff || ctrl.s3_en;
      ctrl.s1_en = !s1_valid_ff || ctrl.s2_en;
      s0_en      = !s0_valid_ff || ctrl.s1_en;
   end

   assign req_port.ready = s0_en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s0_en) s0_valid_ff <= req_port.valid;
         if (ctrl.s1_en) s1_valid_ff <= s0_valid_ff;
         if (ctrl.s2_en) s2_valid_ff <= s1_valid_ff;
         if (ctrl.s3_en) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en) begin
         year_ff      <= req_port.year_value;
         month_ff     <= req_port.month_value;
         day_ff       <= req_port.day_value;
         hour_ff      <= req_port.hour_value;
         minute_ff    <= req_port.minute_value;
         second_ff    <= req_port.second_value;
         subsecond_ff <= req_port.subsecond_word;
         zone_ff      <= req_port.zone_minutes;
         flag_ff      <= req_port.flag_bits;
         reserved_ff  <= req_port.reserved_bytes;
      end
   end

   ctte_check u_check (
      .year_value     (year_ff),
      .month_value    (month_ff),
      .day_value      (day_ff),
      .hour_value     (hour_ff),
      .minute_value   (minute_ff),
      .second_value   (second_ff),
      .subsecond_word (subsecond_ff),
      .zone_minutes   (zone_ff),
      .flag_bits      (flag_ff),
      .reserved_bytes (reserved_ff),
      .fields_ok      (fields_ok)
   );

   ctte_calc u_calc (
      .clock         (clock),
      .ctrl          (ctrl),
      .fields_ok     (fields_ok),
      .year_value    (year_ff),
      .month_value   (month_ff),
      .day_value     (day_ff),
      .hour_value    (hour_ff),
      .minute_value  (minute_ff),
      .second_value  (second_ff),
      .zone_minutes  (zone_ff),
      .is_valid      (rsp_port.is_valid),
      .epoch_seconds (rsp_port.epoch_seconds)
   );

   assign rsp_port.valid = s3_valid_ff;

   `CTTE_NEVER(a_invalid_zero, rsp_port.valid && !rsp_port.is_valid && (rsp_port.epoch_seconds != 32'd0), "invalid word carries nonzero seconds")
   `CTTE_ASSERT(a_accept_loads, (req_port.valid && req_port.ready) |=> s0_valid_ff, "accepted word not captured")
   `CTTE_ASSERT(a_stall_holds, (s2_valid_ff && s3_valid_ff && !rsp_port.ready) |=> (s2_valid_ff && s3_valid_ff), "stalled word dropped")
   `CTTE_ASSERT(a_full_blocks, (s0_valid_ff && s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_port.ready) |-> !req_port.ready, "full pipeline took a word")

endmodule

// File: sim/tb_calendar_time_to_epoch_unit.sv
module tb_calendar_time_to_epoch_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RANDOM_ITEMS = 1500;
   localparam int     PAUSE_AT = 900;
   localparam int     STEADY_FROM = 1100;
   localparam int     STEADY_TO = 1300;
   localparam int     LONG_HOLD_AT = 300;
   localparam int     LONG_HOLD_CYCLES = 400;
   localparam int     DRAIN_CYCLES = 16;
   localparam longint EPOCH_YEAR = 1970;
   localparam longint EPOCH_MAX = 64'h0000_0000_FFFF_FFFF;

   typedef struct {
      logic [15:0]        year_value;
      logic [7:0]         month_value;
      logic [7:0]         day_value;
      logic [7:0]         hour_value;
      logic [7:0]         minute_value;
      logic [7:0]         second_value;
      logic [15:0]        subsecond_word;
      logic signed [15:0] zone_minutes;
      logic [7:0]         flag_bits;
      logic [23:0]        reserved_bytes;
   } time_record_type;

   typedef struct {
      logic        is_valid;
      logic [31:0] epoch_seconds;
   } epoch_result_type;

   logic clock;
   logic reset;

   ctte_req_if req_if ();
   ctte_rsp_if rsp_if ();

   calendar_time_to_epoch_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   time_record_type  record_q[$];
   epoch_result_type epoch_q[$];

   int sent_count = 0;
   int result_count = 0;
   int item_total = 0;
   int mismatch_count = 0;
   int gap_left = 0;
   int burst_left = 1;
   int stall_pct = 0;
   int window_left = 0;
   int hold_count = 0;
   bit hold_done = 1'b0;
   bit long_hold = 1'b0;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint month_span(longint year, longint month);
      bit leap;
      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      case (month)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic longint days_from_year_one(longint year);
      longint p;
      p = year - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic epoch_result_type to_epoch(time_record_type r);
      epoch_result_type res;
      longint           days;
      longint           secs;
      longint           m;
      int               zone;
      bit               ok;
      zone = int'(r.zone_minutes);
      ok = r.year_value >= ctte_pkg::YEAR_MIN && r.year_value <= ctte_pkg::YEAR_MAX &&
           r.month_value >= 8'd1 && r.month_value <= ctte_pkg::MONTH_MAX;
      if (ok && (r.day_value < 8'd1 ||
                 longint'(r.day_value) > month_span(longint'(r.year_value),
                                                    longint'(r.month_value))))
         ok = 1'b0;
      if (r.hour_value > ctte_pkg::HOUR_MAX || r.minute_value > ctte_pkg::MINUTE_MAX ||
          r.second_value > ctte_pkg::SECOND_MAX)
         ok = 1'b0;
      if (r.subsecond_word > ctte_pkg::SUBSECOND_MAX)
         ok = 1'b0;
      if (zone != int'(ctte_pkg::ZONE_UNSPECIFIED) &&
          (zone < -int'(ctte_pkg::ZONE_LIMIT) || zone > int'(ctte_pkg::ZONE_LIMIT)))
         ok = 1'b0;
      if (r.flag_bits[7:2] != 6'd0 || r.reserved_bytes != 24'd0)
         ok = 1'b0;
      secs = 0;
      if (ok) begin
         days = days_from_year_one(longint'(r.year_value)) - days_from_year_one(EPOCH_YEAR);
         for (m = 1; m < longint'(r.month_value); m++)
            days += month_span(longint'(r.year_value), m);
         days += longint'(r.day_value) - 1;
         secs = days * longint'(ctte_pkg::SECONDS_PER_DAY) + longint'(r.hour_value) * 3600 +
                longint'(r.minute_value) * 60 + longint'(r.second_value);
         if (zone != int'(ctte_pkg::ZONE_UNSPECIFIED))
            secs -= longint'(zone) * 60;
         if (secs < 0 || secs > EPOCH_MAX)
            ok = 1'b0;
      end
      res.is_valid = ok;
      res.epoch_seconds = ok ? secs[31:0] : 32'd0;
      return res;
   endfunction

   function automatic time_record_type make_record(int year, int month, int day, int hour,
                                                   int minute, int second, int subsec,
                                                   int zone, int flags, int resv);
      time_record_type r;
      r.year_value = 16'(year);
      r.month_value = 8'(month);
      r.day_value = 8'(day);
      r.hour_value = 8'(hour);
      r.minute_value = 8'(minute);
      r.second_value = 8'(second);
      r.subsecond_word = 16'(subsec);
      r.zone_minutes = 16'(zone);
      r.flag_bits = 8'(flags);
      r.reserved_bytes = 24'(resv);
      return r;
   endfunction

   // Mostly well-formed records in and around the 32-bit range, with one field
   // broken now and then and a share of fully random words.
   function automatic time_record_type random_record();
      time_record_type r;
      int              year;
      int              month;
      int              span;
      if ($urandom_range(0, 99) < 8) begin
         r.year_value = 16'($urandom);
         r.month_value = 8'($urandom);
         r.day_value = 8'($urandom);
         r.hour_value = 8'($urandom);
         r.minute_value = 8'($urandom);
         r.second_value = 8'($urandom);
         r.subsecond_word = 16'($urandom);
         r.zone_minutes = 16'($urandom);
         r.flag_bits = 8'($urandom);
         r.reserved_bytes = 24'($urandom);
         return r;
      end
      case ($urandom_range(0, 9))
         0:       year = 1970;
         1:       year = 2106;
         2:       year = 1969;
         3:       year = int'($urandom_range(1900, 9999));
         default: year = int'($urandom_range(1970, 2106));
      endcase
      month = int'($urandom_range(1, 12));
      span = int'(month_span(longint'(year), longint'(month)));
      r = make_record(year, month, $urandom_range(1, span), $urandom_range(0, 23),
                      $urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 1000),
                      0, $urandom_range(0, 3), 0);
      case ($urandom_range(0, 3))
         0:       r.zone_minutes = ctte_pkg::ZONE_UNSPECIFIED;
         1:       r.zone_minutes = 16'sd0;
         default: r.zone_minutes = 16'(int'($urandom_range(0, 2880)) - 1440);
      endcase
      if ($urandom_range(0, 99) < 25) begin
         case ($urandom_range(0, 9))
            0: r.year_value = 16'($urandom_range(0, 1) ? $urandom_range(0, 1899)
                                                       : $urandom_range(10000, 65535));
            1: r.month_value = 8'($urandom_range(0, 1) ? 0 : $urandom_range(13, 255));
            2: r.day_value = 8'($urandom_range(0, 1) ? 0 : $urandom_range(span + 1, 255));
            3: r.hour_value = 8'($urandom_range(24, 255));
            4: r.minute_value = 8'($urandom_range(60, 255));
            5: r.second_value = 8'($urandom_range(60, 255));
            6: r.subsecond_word = 16'($urandom_range(1001, 65535));
            7: r.zone_minutes = 16'($urandom_range(0, 1) ? int'($urandom_range(1441, 32767))
                                                         : -int'($urandom_range(1441, 32768)));
            8: r.flag_bits = 8'($urandom_range(4, 255));
            default: r.reserved_bytes = 24'($urandom_range(1, 24'hFF_FFFF));
         endcase
      end
      return r;
   endfunction

   task automatic flag_error(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin
      bit took;
      bit offer;
      int sent_now;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         took = req_if.valid && req_if.ready;
         sent_now = sent_count;
         if (took) begin
            epoch_q.push_back(to_epoch(record_q.pop_front()));
            sent_now++;
            sent_count <= sent_now;
         end
         if (!req_if.valid || took) begin
            offer = 1'b0;
            if (record_q.size() != 0 && !(sent_now == PAUSE_AT && result_count != sent_now)) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  offer = 1'b1;
                  if (sent_now < STEADY_FROM || sent_now >= STEADY_TO) begin
                     burst_left--;
                     if (burst_left <= 0) begin
                        burst_left = int'($urandom_range(1, 32));
                        gap_left = ($urandom_range(0, 3) == 0) ? 0
                                   : int'($urandom_range(1, 6));
                     end
                  end
               end
            end
            req_if.valid <= offer;
            if (offer) begin
               req_if.year_value <= record_q[0].year_value;
               req_if.month_value <= record_q[0].month_value;
               req_if.day_value <= record_q[0].day_value;
               req_if.hour_value <= record_q[0].hour_value;
               req_if.minute_value <= record_q[0].minute_value;
               req_if.second_value <= record_q[0].second_value;
               req_if.subsecond_word <= record_q[0].subsecond_word;
               req_if.zone_minutes <= record_q[0].zone_minutes;
               req_if.flag_bits <= record_q[0].flag_bits;
               req_if.reserved_bytes <= record_q[0].reserved_bytes;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         hold_count <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && result_count >= LONG_HOLD_AT) begin
         if (hold_count < LONG_HOLD_CYCLES) begin
            long_hold <= 1'b1;
            hold_count <= hold_count + 1;
         end else begin
            long_hold <= 1'b0;
            hold_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_pct <= 0;
         window_left <= 0;
      end else begin
         if (window_left == 0) begin
            window_left <= 64;
            case ($urandom_range(0, 3))
               0:       stall_pct <= 0;
               1:       stall_pct <= 25;
               2:       stall_pct <= 50;
               default: stall_pct <= 85;
            endcase
         end else begin
            window_left <= window_left - 1;
         end
         rsp_if.ready <= !long_hold && (int'($urandom_range(0, 99)) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      epoch_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_count <= result_count + 1;
         if (epoch_q.size() == 0) begin
            flag_error("unexpected word, epoch_seconds", -1, longint'(rsp_if.epoch_seconds));
         end else begin
            want = epoch_q.pop_front();
            if (rsp_if.is_valid !== want.is_valid)
               flag_error("is_valid", longint'(want.is_valid), longint'(rsp_if.is_valid));
            if (rsp_if.epoch_seconds !== want.epoch_seconds)
               flag_error("epoch_seconds", longint'(want.epoch_seconds),
                          longint'(rsp_if.epoch_seconds));
         end
      end
   end

   initial begin
      int i;
      reset = 1'b1;
      rsp_if.ready = 1'b0;
      req_if.valid = 1'b0;
      req_if.year_value = '0;
      req_if.month_value = '0;
      req_if.day_value = '0;
      req_if.hour_value = '0;
      req_if.minute_value = '0;
      req_if.second_value = '0;
      req_if.subsecond_word = '0;
      req_if.zone_minutes = '0;
      req_if.flag_bits = '0;
      req_if.reserved_bytes = '0;

      // Ends of the 32-bit range, leap-year rules and each field just past its limit.
      record_q.push_back(make_record(1970, 1, 1, 0, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(1970, 1, 1, 0, 0, 0, 0, 1, 0, 0));
      record_q.push_back(make_record(1969, 12, 31, 23, 0, 0, 0, -60, 0, 0));
      record_q.push_back(make_record(2106, 2, 7, 6, 28, 15, 1000, 2047, 3, 0));
      record_q.push_back(make_record(2106, 2, 7, 6, 28, 16, 0, 2047, 0, 0));
      record_q.push_back(make_record(9999, 12, 31, 23, 59, 59, 0, 1440, 1, 0));
      record_q.push_back(make_record(1900, 1, 1, 0, 0, 0, 0, -1440, 2, 0));
      record_q.push_back(make_record(1899, 6, 1, 0, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(10000, 6, 1, 0, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2000, 2, 29, 12, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2100, 2, 29, 12, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2024, 2, 29, 12, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2023, 2, 29, 12, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 4, 31, 0, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 13, 1, 0, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 3, 1, 24, 0, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 3, 1, 0, 60, 0, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 3, 1, 0, 0, 60, 0, 0, 0, 0));
      record_q.push_back(make_record(2021, 3, 1, 0, 0, 0, 1001, 0, 0, 0));
      record_q.push_back(make_record(2021, 3, 1, 0, 0, 0, 0, 1441, 0, 0));
      record_q.push_back(make_record(2021, 3, 1, 0, 0, 0, 0, -1441, 0, 0));
      record_q.push_back(make_record(2021, 3, 1, 0, 0, 0, 0, 0, 4, 0));
      record_q.push_back(make_record(2021, 3, 1, 0, 0, 0, 0, 0, 0, 24'h80_0000));
      for (i = 0; i < RANDOM_ITEMS; i++)
         record_q.push_back(random_record());
      item_total = record_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (sent_count < item_total || result_count < item_total)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (epoch_q.size() != 0)
         flag_error("words still outstanding", 0, longint'(epoch_q.size()));
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
